// ===== rtl/assert_macros.svh =====
// Assertion macros for the page allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DCPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DCPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DCPA_ASSERT_IMP(lbl, ante, cons, msg)
`define DCPA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/dcpa_pkg.sv =====
// Shared types and codes for the contiguous page allocator.
package dcpa_pkg;

    typedef enum logic [1:0] {
        K_ALLOC = 2'd0,
        K_USED  = 2'd1,
        K_FREE  = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MODA_GO,
        S_MODA_WAIT,
        S_MODB_GO,
        S_MODB_WAIT,
        S_SCAN,
        S_FILL
    } t_state;

    typedef struct packed {
        logic start;
    } t_mod_ctl;

    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } t_mod_sts;

endpackage

// ===== rtl/dma_contiguous_page_allocator.sv =====
// Contiguous page allocator: bitmap scan with one page read per cycle.
// Reset: bitmap cleared by a pass over all NUM_PAGES pages; busy stays high meanwhile.
// Mark item: result strobe in the cycle after start; next item may follow at once.
// Allocate: remainder setup in the divider (alignment, then boundary), then a scan
// of pages up to the search limit (bitmap read port), then a write per allocated
// page to mark the run used, then the result strobe.
// Results cannot be stalled; each is marked by a strobe that is high for a single cycle.
module dma_contiguous_page_allocator #(
    parameter int NUM_PAGES  = 4096,
    parameter int PAGE_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_size_bytes,
    input  logic [31:0] i_alignment,
    input  logic [31:0] i_boundary,
    input  logic [31:0] i_max_address,
    input  logic [11:0] i_page_index,
    output logic        o_strobe,
    output logic        o_found,
    output logic [23:0] o_address
);
    import dcpa_pkg::*;

    localparam int AW  = $clog2(NUM_PAGES);
    localparam int LW  = $clog2(NUM_PAGES + 1);
    localparam int PS  = $clog2(PAGE_BYTES);
    localparam int PGW = 33 - PS;

    t_state        r_state, n_state;
    logic [AW-1:0] r_wp;
    logic [LW-1:0] r_rd, r_pp, r_limit, r_cnt;
    logic          r_pv, r_have;
    logic [AW-1:0] r_cand;
    logic [31:0]   r_size, r_align, r_bound, r_pma, r_pmb, r_ra, r_rb;
    logic [PGW-1:0] r_pages;
    logic          r_strobe, r_found;
    logic [23:0]   r_addr;

    logic          mem_we, mem_wd, mem_rd;
    logic [AW-1:0] mem_wa;
    t_mod_ctl      mod_ctl;
    t_mod_sts      mod_sts;
    logic [31:0]   mod_div;

    logic [31:0]   lim_q;
    logic [LW-1:0] in_limit;
    logic [32:0]   pg_sum;
    logic          is_mark, in_range;
    logic          aligned, nocross, starts, cont, hit, issue, scan_end;
    logic [LW-1:0] cnew;
    logic [AW-1:0] cand_now;
    logic [32:0]   ra_sum, rb_sum, cross_sum;
    logic [63:0]   addr_w;

    dcpa_bitmap #(.DEPTH(NUM_PAGES), .AW(AW)) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_wa),
        .i_wdata (mem_wd),
        .i_raddr (r_rd[AW-1:0]),
        .o_rdata (mem_rd)
    );

    dcpa_modu #(.DIVIDEND(PAGE_BYTES)) u_modu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mod_ctl),
        .i_div   (mod_div),
        .o_sts   (mod_sts)
    );

    // decode of the incoming word
    always_comb begin
        lim_q    = i_max_address >> PS;
        if (i_max_address == '0 || lim_q >= 32'(NUM_PAGES)) begin
            in_limit = LW'(NUM_PAGES);
        end else begin
            in_limit = LW'(lim_q);
        end
        pg_sum   = {1'b0, i_size_bytes} + 33'(PAGE_BYTES - 1);
        is_mark  = (i_kind == K_USED) || (i_kind == K_FREE);
        in_range = (32'(i_page_index) < 32'(NUM_PAGES));
    end

    // scan step for the page whose bit is on the read port
    always_comb begin
        aligned   = (r_align == '0) || (r_ra == '0);
        cross_sum = {1'b0, r_rb} + {1'b0, r_size};
        nocross   = (r_bound == '0) || (cross_sum <= {1'b0, r_bound});
        starts    = !r_have && !mem_rd && aligned && nocross;
        cont      = r_have && !mem_rd;
        cnew      = r_have ? r_cnt + 1'b1 : LW'(1);
        cand_now  = r_have ? r_cand : r_pp[AW-1:0];
        hit       = r_pv && (starts || cont) && (33'(cnew) == 33'(r_pages));
        issue     = (r_rd < r_limit);
        scan_end  = !r_pv && !issue;
        ra_sum    = {1'b0, r_ra} + {1'b0, r_pma};
        if (ra_sum >= {1'b0, r_align}) begin
            ra_sum = ra_sum - {1'b0, r_align};
        end
        rb_sum    = {1'b0, r_rb} + {1'b0, r_pmb};
        if (rb_sum >= {1'b0, r_bound}) begin
            rb_sum = rb_sum - {1'b0, r_bound};
        end
        addr_w    = 64'(r_cand) << PS;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_wp == AW'(NUM_PAGES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start && i_kind == K_ALLOC && i_size_bytes != '0) n_state = S_MODA_GO;
            end
            S_MODA_GO:   n_state = S_MODA_WAIT;
            S_MODA_WAIT: begin
                if (mod_sts.done) n_state = S_MODB_GO;
            end
            S_MODB_GO:   n_state = S_MODB_WAIT;
            S_MODB_WAIT: begin
                if (mod_sts.done) n_state = S_SCAN;
            end
            S_SCAN: begin
                priority if (hit) n_state = S_FILL;
                else if (scan_end) n_state = S_IDLE;
            end
            S_FILL: begin
                if (r_cnt == LW'(1)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory and divider controls
    always_comb begin
        mem_we        = 1'b0;
        mem_wa        = r_wp;
        mem_wd        = 1'b1;
        mod_ctl.start = 1'b0;
        mod_div       = r_align;
        busy          = 1'b1;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wd = 1'b0;
            end
            S_IDLE: begin
                busy   = 1'b0;
                mem_we = start && is_mark && in_range;
                mem_wa = AW'(i_page_index);
                mem_wd = (i_kind == K_USED);
            end
            S_MODA_GO: mod_ctl.start = 1'b1;
            S_MODA_WAIT: begin
            end
            S_MODB_GO: begin
                mod_ctl.start = 1'b1;
                mod_div       = r_bound;
            end
            S_MODB_WAIT: mod_div = r_bound;
            S_SCAN: begin
            end
            S_FILL: mem_we = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_wp     <= '0;
            r_strobe <= 1'b0;
            r_pv     <= 1'b0;
            r_have   <= 1'b0;
            r_rd     <= '0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            unique case (r_state)
                S_CLEAR: r_wp <= r_wp + 1'b1;
                S_IDLE: begin
                    if (start) begin
                        r_size  <= i_size_bytes;
                        r_align <= i_alignment;
                        r_bound <= i_boundary;
                        r_limit <= in_limit;
                        r_pages <= pg_sum[32:PS];
                        r_rd    <= '0;
                        r_pp    <= '0;
                        r_pv    <= 1'b0;
                        r_have  <= 1'b0;
                        r_ra    <= '0;
                        r_rb    <= '0;
                        r_addr  <= '0;
                        if (i_kind != K_ALLOC || i_size_bytes == '0) begin
                            r_strobe <= 1'b1;
                            r_found  <= is_mark && in_range;
                        end
                    end
                end
                S_MODA_GO: begin
                end
                S_MODA_WAIT: begin
                    if (mod_sts.done) r_pma <= mod_sts.rem;
                end
                S_MODB_GO: begin
                end
                S_MODB_WAIT: begin
                    if (mod_sts.done) r_pmb <= mod_sts.rem;
                end
                S_SCAN: begin
                    if (issue) r_rd <= r_rd + 1'b1;
                    r_pv <= issue;
                    if (r_pv) begin
                        r_pp <= r_pp + 1'b1;
                        r_ra <= ra_sum[31:0];
                        r_rb <= rb_sum[31:0];
                        r_have <= starts || cont;
                        r_cand <= cand_now;
                        r_cnt  <= cnew;
                        if (hit) begin
                            r_wp <= cand_now;
                            r_pv <= 1'b0;
                        end
                    end
                    if (!hit && scan_end) begin
                        r_strobe <= 1'b1;
                        r_found  <= 1'b0;
                    end
                end
                S_FILL: begin
                    r_wp  <= r_wp + 1'b1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == LW'(1)) begin
                        r_strobe <= 1'b1;
                        r_found  <= 1'b1;
                        r_addr   <= addr_w[23:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_strobe  = r_strobe;
    assign o_found   = r_found;
    assign o_address = r_addr;

    `include "assert_macros.svh"

    `DCPA_ASSERT_IMP(a_nf_zero, o_strobe && !o_found, o_address == '0, "address set without found")
    `DCPA_ASSERT_NXT(a_mark_ack, start && !busy && i_kind != K_ALLOC, o_strobe && !busy, "mark word not answered")
    `DCPA_ASSERT_IMP(a_fill_cnt, r_state == S_FILL, r_cnt != '0, "fill count empty")
    `DCPA_ASSERT_NXT(a_alloc_busy, start && !busy && i_kind == K_ALLOC && i_size_bytes != '0, busy && !o_strobe, "allocate word left early")
endmodule

// ===== rtl/dcpa_bitmap.sv =====
// Page-used bitmap memory, one write port and one registered read port.
module dcpa_bitmap #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);
    logic mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== rtl/dcpa_modu.sv =====
// Bit-serial remainder of a constant dividend by a 32-bit divisor.
module dcpa_modu #(
    parameter int DIVIDEND = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dcpa_pkg::t_mod_ctl   i_ctl,
    input  logic [31:0]          i_div,
    output dcpa_pkg::t_mod_sts   o_sts
);
    import dcpa_pkg::*;

    localparam int DW = $clog2(DIVIDEND) + 1;
    localparam int CW = $clog2(DW + 1);
    localparam logic [DW-1:0] NUMER = DW'(DIVIDEND);

    logic [DW-1:0] r_num;
    logic [31:0]   r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [32:0]   trial;

    always_comb begin
        trial = {r_rem, r_num[DW-1]};
        if (trial >= {1'b0, i_div}) begin
            trial = trial - {1'b0, i_div};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_num <= NUMER;
                r_rem <= '0;
                r_cnt <= CW'(DW);
            end else if (r_cnt != '0) begin
                // one dividend bit per cycle, MSB first
                r_num <= r_num << 1;
                r_rem <= trial[31:0];
                r_cnt <= r_cnt - 1'b1;
                r_done <= (r_cnt == CW'(1));
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.rem  = r_rem;
endmodule
